// File: sv/tid_pkg.sv
// tid_pkg: widths, register indexes, sequencer states and helpers for the
// thrust imbalance detector. No dependencies; every other file depends on it.
`default_nettype none

package tid_pkg;

  // time base width, wrapping
  localparam int TIME_BITS = 32;

  // field widths
  localparam int NOW_W      = 32;
  localparam int THROTTLE_W = 7;
  localparam int RATE_W     = 12;
  localparam int INTEG_W    = 16;
  localparam int THR_W      = 8;
  localparam int DELAY_W    = 8;
  localparam int INHIBIT_W  = 24;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIG_DELAY    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNTRIG_DELAY  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_LIMIT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_THROTTLE_MIN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INHIBIT_TIME  = 3'd5;

  // register reset values
  localparam logic [THR_W-1:0]      RST_THRESHOLD    = 8'd0;
  localparam logic [DELAY_W-1:0]    RST_TRIG_DELAY   = 8'd10;
  localparam logic [DELAY_W-1:0]    RST_UNTRIG_DELAY = 8'd10;
  localparam logic [RATE_W-1:0]     RST_RATE_LIMIT   = 12'd200;
  localparam logic [THROTTLE_W-1:0] RST_THROTTLE_MIN = 7'd10;
  localparam logic [INHIBIT_W-1:0]  RST_INHIBIT_TIME = 24'd500000;

  // shared multiplier operand widths
  localparam int MUL_A_W = 31;   // up to 2^30 (product of two magnitudes)
  localparam int MUL_B_W = 17;   // one magnitude, up to 2^15
  localparam int MUL_W   = MUL_A_W + MUL_B_W;
  localparam int MAG_W   = 46;   // |product| of three magnitudes
  localparam int DLY_W   = 25;   // 255 * 100000 fits here

  // scale factors: Q11.4 cubed gives 4096, threshold unit is 100000
  localparam logic [MUL_A_W-1:0] THR_SCALE    = 31'd409600000;
  localparam logic [MUL_A_W-1:0] US_PER_TENTH = 31'd100000;

  typedef logic [TIME_BITS-1:0] time_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_AB,
    ST_MUL_C,
    ST_MUL_THR,
    ST_MUL_TRIG,
    ST_TRIG,
    ST_TRIG_CHK,
    ST_UNTRIG,
    ST_OUT
  } tid_state_t;

  // command to the shared arithmetic unit
  typedef struct packed {
    logic               mul_en;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    time_t              add_a;
    time_t              add_b;
    logic               add_sub;
  } arith_op_t;

  // magnitude of a 16-bit two's complement value
  function automatic logic [MUL_B_W-1:0] abs16(input logic [INTEG_W-1:0] x);
    logic [MUL_B_W-1:0] v;
    v = {1'b0, x};
    return x[INTEG_W-1] ? (17'h10000 - v) : v;
  endfunction

endpackage

`default_nettype wire

// File: sv/tid_ifs.sv
// tid_ifs: valid/ready channel interfaces for ticks, results and
// configuration writes. Depends on tid_pkg for field widths.
`default_nettype none

interface tid_tick_if;
  logic                                valid;
  logic                                ready;
  logic [tid_pkg::NOW_W-1:0]           now_us;
  logic                                active;
  logic [tid_pkg::THROTTLE_W-1:0]      throttle_percent;
  logic [tid_pkg::RATE_W-1:0]          roll_rate_dps;
  logic [tid_pkg::RATE_W-1:0]          pitch_rate_dps;
  logic [tid_pkg::RATE_W-1:0]          yaw_rate_dps;
  logic signed [tid_pkg::INTEG_W-1:0]  roll_integral;
  logic signed [tid_pkg::INTEG_W-1:0]  pitch_integral;
  logic signed [tid_pkg::INTEG_W-1:0]  yaw_integral;

  modport source (
    output valid, now_us, active, throttle_percent, roll_rate_dps, pitch_rate_dps,
           yaw_rate_dps, roll_integral, pitch_integral, yaw_integral,
    input  ready
  );
  modport sink (
    input  valid, now_us, active, throttle_percent, roll_rate_dps, pitch_rate_dps,
           yaw_rate_dps, roll_integral, pitch_integral, yaw_integral,
    output ready
  );
endinterface

interface tid_result_if;
  logic valid;
  logic ready;
  logic imbalance_detected;
  logic detection_enabled;

  modport source (output valid, imbalance_detected, detection_enabled, input ready);
  modport sink   (input valid, imbalance_detected, detection_enabled, output ready);
endinterface

interface tid_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [tid_pkg::CFG_IDX_W-1:0]   index;
  logic [tid_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: sv/tid_arith.sv
// tid_arith: shared arithmetic unit, one registered multiplier and one
// add/subtract for wrapping time. Depends on tid_pkg.
`default_nettype none

module tid_arith (
  input  logic                      clk,
  input  tid_pkg::arith_op_t        op,
  output logic [tid_pkg::MUL_W-1:0] mul_q,
  output tid_pkg::time_t            add_y
);
  import tid_pkg::*;

  // multiplier with output register, holds when not commanded
  always_ff @(posedge clk) begin
    if (op.mul_en) begin
      mul_q <= MUL_W'(op.mul_a) * MUL_W'(op.mul_b);
    end
  end

  // wrapping add or subtract
  assign add_y = op.add_a + (op.add_sub ? ~op.add_b : op.add_b) + TIME_BITS'(op.add_sub);

endmodule

`default_nettype wire

// File: sv/thrust_imbalance_detector_top.sv
// thrust_imbalance_detector_top: per-tick thrust imbalance detector.
// Depends on tid_pkg, tid_ifs (channel interfaces) and tid_arith.
//
// Usage:
//   tick   - one transaction per control-loop tick (time, active flag,
//            throttle, absolute gyro rates, PID integrals)
//   result - exactly one transaction per tick: imbalance flag and whether
//            detection was enabled this tick
//   cfg    - register writes (index, data), always ready; write only while
//            no tick is in flight
// Sequencing: a tick is processed by a small sequencer driving one shared
//   multiplier and one adder. An inactive tick (or zero threshold) goes
//   straight to the output step; an active tick first passes through the
//   multiplier steps (two product steps, threshold scaling, delay scaling)
//   and the trigger/untrigger time checks.
//   tick.ready is high only while the sequencer is idle, so a new tick is
//   accepted only once the previous one has left the output step.
// Stall: the result sits in an output register; the next tick is accepted
//   while it waits, and the sequencer holds its final step until the
//   register frees up.
// Reset: synchronous; timers, inhibit window and flag clear to zero and
//   registers take their default values.
`default_nettype none

module thrust_imbalance_detector_top (
  input logic          clk,
  input logic          rst,
  tid_tick_if.sink     tick,
  tid_result_if.source result,
  tid_cfg_if.sink      cfg
);
  import tid_pkg::*;

  // configuration registers
  logic [THR_W-1:0]      imbalance_threshold;
  logic [DELAY_W-1:0]    trigger_delay_tenths;
  logic [DELAY_W-1:0]    untrigger_delay_tenths;
  logic [RATE_W-1:0]     rate_limit_dps;
  logic [THROTTLE_W-1:0] throttle_floor;
  logic [INHIBIT_W-1:0]  inhibit_time_us;

  // detector state
  time_t trigger_time;
  time_t untrigger_time;
  time_t inhibit_until;
  logic  detected_flag;

  // latched tick
  time_t                 now_q;
  logic [THROTTLE_W-1:0] throttle_q;
  logic [RATE_W-1:0]     roll_rate_q;
  logic [RATE_W-1:0]     pitch_rate_q;
  logic [RATE_W-1:0]     yaw_rate_q;
  logic [INTEG_W-1:0]    roll_int_q;
  logic [INTEG_W-1:0]    pitch_int_q;
  logic [INTEG_W-1:0]    yaw_int_q;

  // intermediate results
  logic [MAG_W-1:0] mag_q;
  logic             enabled_q;
  logic             over_q;

  // output register
  logic res_valid;
  logic res_detected;
  logic res_enabled;

  tid_state_t       state;
  tid_state_t       state_next;
  arith_op_t        op;
  logic [MUL_W-1:0] mul_q;
  time_t            add_y;
  logic             go_in;
  logic             inhibit_hit;
  logic             out_free;

  tid_arith u_arith (
    .clk   (clk),
    .op    (op),
    .mul_q (mul_q),
    .add_y (add_y)
  );

  assign go_in       = tick.active && (imbalance_threshold != '0);
  assign inhibit_hit = (throttle_q < throttle_floor) || (roll_rate_q > rate_limit_dps) ||
                       (pitch_rate_q > rate_limit_dps) || (yaw_rate_q > rate_limit_dps);
  assign out_free    = !res_valid || result.ready;

  assign tick.ready                = (state == ST_IDLE);
  assign cfg.ready                 = 1'b1;
  assign result.valid              = res_valid;
  assign result.imbalance_detected = res_detected;
  assign result.detection_enabled  = res_enabled;

  // sequencer: next state and arithmetic commands
  always_comb begin
    state_next = state;
    op         = '0;
    unique case (state)
      ST_IDLE: begin
        if (tick.valid) begin
          state_next = go_in ? ST_MUL_AB : ST_OUT;
        end
      end
      ST_MUL_AB: begin
        op.mul_en  = 1'b1;
        op.mul_a   = MUL_A_W'(abs16(roll_int_q));
        op.mul_b   = abs16(pitch_int_q);
        op.add_a   = now_q;
        op.add_b   = TIME_BITS'(inhibit_time_us);
        state_next = ST_MUL_C;
      end
      ST_MUL_C: begin
        op.mul_en  = 1'b1;
        op.mul_a   = mul_q[MUL_A_W-1:0];
        op.mul_b   = abs16(yaw_int_q);
        op.add_a   = now_q;
        op.add_b   = inhibit_until;
        op.add_sub = 1'b1;
        state_next = ST_MUL_THR;
      end
      ST_MUL_THR: begin
        op.mul_en  = 1'b1;
        op.mul_a   = THR_SCALE;
        op.mul_b   = MUL_B_W'(imbalance_threshold);
        state_next = ST_MUL_TRIG;
      end
      ST_MUL_TRIG: begin
        op.mul_en  = 1'b1;
        op.mul_a   = US_PER_TENTH;
        op.mul_b   = MUL_B_W'(trigger_delay_tenths);
        state_next = ST_TRIG;
      end
      ST_TRIG: begin
        op.add_a = now_q;
        if (enabled_q && over_q) begin
          // trigger deadline, and start the untrigger delay product
          op.mul_en  = 1'b1;
          op.mul_a   = US_PER_TENTH;
          op.mul_b   = MUL_B_W'(untrigger_delay_tenths);
          op.add_b   = TIME_BITS'(mul_q[DLY_W-1:0]);
          state_next = ST_TRIG_CHK;
        end else begin
          // release check against the untrigger deadline
          op.add_b   = untrigger_time;
          op.add_sub = 1'b1;
          state_next = ST_OUT;
        end
      end
      ST_TRIG_CHK: begin
        op.add_a   = now_q;
        op.add_b   = trigger_time;
        op.add_sub = 1'b1;
        state_next = add_y[TIME_BITS-1] ? ST_OUT : ST_UNTRIG;
      end
      ST_UNTRIG: begin
        op.add_a   = now_q;
        op.add_b   = TIME_BITS'(mul_q[DLY_W-1:0]);
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      imbalance_threshold    <= RST_THRESHOLD;
      trigger_delay_tenths   <= RST_TRIG_DELAY;
      untrigger_delay_tenths <= RST_UNTRIG_DELAY;
      rate_limit_dps         <= RST_RATE_LIMIT;
      throttle_floor         <= RST_THROTTLE_MIN;
      inhibit_time_us        <= RST_INHIBIT_TIME;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_THRESHOLD:    imbalance_threshold    <= cfg.data[THR_W-1:0];
        CFG_TRIG_DELAY:   trigger_delay_tenths   <= cfg.data[DELAY_W-1:0];
        CFG_UNTRIG_DELAY: untrigger_delay_tenths <= cfg.data[DELAY_W-1:0];
        CFG_RATE_LIMIT:   rate_limit_dps         <= cfg.data[RATE_W-1:0];
        CFG_THROTTLE_MIN: throttle_floor         <= cfg.data[THROTTLE_W-1:0];
        CFG_INHIBIT_TIME: inhibit_time_us        <= cfg.data[INHIBIT_W-1:0];
        default: ;
      endcase
    end
  end

  // detector state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_time   <= '0;
      untrigger_time <= '0;
      inhibit_until  <= '0;
      detected_flag  <= 1'b0;
      res_valid      <= 1'b0;
    end else begin
      // loaded from the final step, held until the receiver takes it
      res_valid <= ((state == ST_OUT) && out_free) || (res_valid && !result.ready);
      case (state)
        ST_IDLE: begin
          if (tick.valid) begin
            now_q        <= TIME_BITS'(tick.now_us);
            throttle_q   <= tick.throttle_percent;
            roll_rate_q  <= tick.roll_rate_dps;
            pitch_rate_q <= tick.pitch_rate_dps;
            yaw_rate_q   <= tick.yaw_rate_dps;
            roll_int_q   <= tick.roll_integral;
            pitch_int_q  <= tick.pitch_integral;
            yaw_int_q    <= tick.yaw_integral;
            enabled_q    <= 1'b0;
            // idle tick clears timers and flag
            if (!go_in) begin
              trigger_time   <= '0;
              untrigger_time <= '0;
              detected_flag  <= 1'b0;
            end
          end
        end
        ST_MUL_AB: begin
          if (inhibit_hit) begin
            inhibit_until <= add_y;
          end
        end
        ST_MUL_C: begin
          // inhibit window passed when now - inhibit_until is not negative
          enabled_q <= !add_y[TIME_BITS-1];
          if (!add_y[TIME_BITS-1]) begin
            inhibit_until <= '0;
          end
        end
        ST_MUL_THR: begin
          mag_q <= mul_q[MAG_W-1:0];
        end
        ST_MUL_TRIG: begin
          over_q <= (MUL_W'(mag_q) >= mul_q);
        end
        ST_TRIG: begin
          if (enabled_q && over_q) begin
            if (trigger_time == '0) begin
              trigger_time <= add_y;
            end
          end else begin
            trigger_time <= '0;
            if ((untrigger_time != '0) && !add_y[TIME_BITS-1]) begin
              untrigger_time <= '0;
              detected_flag  <= 1'b0;
            end
          end
        end
        ST_UNTRIG: begin
          untrigger_time <= add_y;
          detected_flag  <= 1'b1;
        end
        ST_OUT: begin
          if (out_free) begin
            res_detected <= detected_flag;
            res_enabled  <= enabled_q;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: verif/tb_top.sv
// tb_top: self-checking testbench for thrust_imbalance_detector_top.
// Depends on tid_pkg and tid_ifs; holds a scoreboard package with its own
// flag predictor, plus the stimulus, stall and checking logic.
`timescale 1ns / 1ps

package tid_tb_pkg;
  import tid_pkg::*;

  // one control-loop tick as driven on the tick channel
  typedef struct {
    time_t                     now_us;
    logic                      active;
    logic [THROTTLE_W-1:0]     throttle_percent;
    logic [RATE_W-1:0]         roll_rate_dps;
    logic [RATE_W-1:0]         pitch_rate_dps;
    logic [RATE_W-1:0]         yaw_rate_dps;
    logic signed [INTEG_W-1:0] roll_integral;
    logic signed [INTEG_W-1:0] pitch_integral;
    logic signed [INTEG_W-1:0] yaw_integral;
  } tick_t;

  typedef struct {
    logic imbalance_detected;
    logic detection_enabled;
  } flags_t;

  localparam time_t TENTH_US = 32'd100000;
  // Q11.4 cubed scales by 4096, threshold unit is 100000
  localparam logic [63:0] PRODUCT_UNIT = 64'd409600000;
  // index past the register list, must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;

  class flag_scoreboard;
    logic [THR_W-1:0]      threshold;
    logic [DELAY_W-1:0]    trig_tenths;
    logic [DELAY_W-1:0]    untrig_tenths;
    logic [RATE_W-1:0]     rate_limit;
    logic [THROTTLE_W-1:0] throttle_min;
    logic [INHIBIT_W-1:0]  inhibit_us;
    time_t                 trig_at;
    time_t                 untrig_at;
    time_t                 inhibit_until;
    logic                  flagged;
    flags_t                pending_flags[$];
    int                    errors;

    function new();
      threshold     = RST_THRESHOLD;
      trig_tenths   = RST_TRIG_DELAY;
      untrig_tenths = RST_UNTRIG_DELAY;
      rate_limit    = RST_RATE_LIMIT;
      throttle_min  = RST_THROTTLE_MIN;
      inhibit_us    = RST_INHIBIT_TIME;
      trig_at       = '0;
      untrig_at     = '0;
      inhibit_until = '0;
      flagged       = 1'b0;
      errors        = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_THRESHOLD:    threshold     = data[THR_W-1:0];
        CFG_TRIG_DELAY:   trig_tenths   = data[DELAY_W-1:0];
        CFG_UNTRIG_DELAY: untrig_tenths = data[DELAY_W-1:0];
        CFG_RATE_LIMIT:   rate_limit    = data[RATE_W-1:0];
        CFG_THROTTLE_MIN: throttle_min  = data[THROTTLE_W-1:0];
        CFG_INHIBIT_TIME: inhibit_us    = data[INHIBIT_W-1:0];
        default: ;
      endcase
    endfunction

    // wrapped difference decides, top bit set means not yet
    static function bit deadline_passed(time_t now, time_t deadline);
      time_t diff;
      diff = now - deadline;
      return !diff[TIME_BITS-1];
    endfunction

    static function logic [63:0] magnitude(logic signed [INTEG_W-1:0] x);
      logic signed [INTEG_W:0] w;
      logic [63:0] m;
      w = x;
      if (w < 0) m = -w;
      else m = w;
      return m;
    endfunction

    // advance the detector state by one accepted tick
    function void note_tick(tick_t t);
      flags_t f;
      time_t trig_dly;
      time_t untrig_dly;
      logic [63:0] mag;
      bit over;
      f.detection_enabled = 1'b0;
      if (t.active && threshold != 0) begin
        trig_dly   = trig_tenths * TENTH_US;
        untrig_dly = untrig_tenths * TENTH_US;
        if (t.throttle_percent < throttle_min || t.roll_rate_dps > rate_limit ||
            t.pitch_rate_dps > rate_limit || t.yaw_rate_dps > rate_limit)
          inhibit_until = t.now_us + inhibit_us;
        f.detection_enabled = deadline_passed(t.now_us, inhibit_until);
        if (f.detection_enabled) inhibit_until = '0;
        mag = magnitude(t.roll_integral) * magnitude(t.pitch_integral) *
              magnitude(t.yaw_integral);
        over = (mag >= threshold * PRODUCT_UNIT);
        if (f.detection_enabled && over) begin
          // zero marks an unset deadline, so it is recomputed next tick
          if (trig_at == 0) trig_at = t.now_us + trig_dly;
          if (deadline_passed(t.now_us, trig_at)) begin
            untrig_at = t.now_us + untrig_dly;
            flagged   = 1'b1;
          end
        end else begin
          trig_at = '0;
          if (untrig_at != 0 && deadline_passed(t.now_us, untrig_at)) begin
            untrig_at = '0;
            flagged   = 1'b0;
          end
        end
      end else begin
        trig_at   = '0;
        untrig_at = '0;
        flagged   = 1'b0;
      end
      f.imbalance_detected = flagged;
      pending_flags.push_back(f);
    endfunction

    function void check_flags(logic imbalance, logic enabled);
      flags_t exp_f;
      if (pending_flags.size() == 0) begin
        $error("result with nothing pending: imbalance_detected=%0b detection_enabled=%0b",
               imbalance, enabled);
        errors++;
        return;
      end
      exp_f = pending_flags.pop_front();
      if (imbalance !== exp_f.imbalance_detected) begin
        $error("imbalance_detected: expected %0b, actual %0b",
               exp_f.imbalance_detected, imbalance);
        errors++;
      end
      if (enabled !== exp_f.detection_enabled) begin
        $error("detection_enabled: expected %0b, actual %0b",
               exp_f.detection_enabled, enabled);
        errors++;
      end
    endfunction

    function int pending();
      return pending_flags.size();
    endfunction
  endclass
endpackage

module tb_top;
  import tid_pkg::*;
  import tid_tb_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int PHASES       = 10;
  localparam int PHASE_TICKS  = 180;
  localparam int DRAIN_CYCLES = 12;

  typedef struct {
    logic [THR_W-1:0]      threshold;
    logic [DELAY_W-1:0]    trig_tenths;
    logic [DELAY_W-1:0]    untrig_tenths;
    logic [RATE_W-1:0]     rate_limit;
    logic [THROTTLE_W-1:0] throttle_min;
    logic [INHIBIT_W-1:0]  inhibit_us;
  } setting_t;

  logic clk;
  logic rst;
  int unsigned cycles = 0;

  tid_tick_if   tick();
  tid_result_if result();
  tid_cfg_if    cfg();

  thrust_imbalance_detector_top dut (
    .clk    (clk),
    .rst    (rst),
    .tick   (tick),
    .result (result),
    .cfg    (cfg)
  );

  flag_scoreboard sb;

  // stimulus shaping for the current setting
  setting_t    cur;
  int unsigned axis_min;
  int unsigned step_max;
  time_t       clock_us;
  int          burst_left;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // run watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // result side: check each transaction, stall on a pattern of its own
  initial begin
    int mode;
    int mode_left;
    mode = 0;
    mode_left = 0;
    result.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result.valid && result.ready)
        sb.check_flags(result.imbalance_detected, result.detection_enabled);
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      case (mode)
        0: result.ready <= 1'b1;
        1: result.ready <= ($urandom_range(0, 3) != 0);
        2: result.ready <= ($urandom_range(0, 3) == 0);
        default: result.ready <= (mode_left % 25 == 0);
      endcase
    end
  end

  function automatic tick_t mk_tick(time_t now, logic act, logic [THROTTLE_W-1:0] thr,
                                    logic [RATE_W-1:0] rr, logic [RATE_W-1:0] pr,
                                    logic [RATE_W-1:0] yr, logic signed [INTEG_W-1:0] ri,
                                    logic signed [INTEG_W-1:0] pit,
                                    logic signed [INTEG_W-1:0] yi);
    tick_t t;
    t.now_us = now;
    t.active = act;
    t.throttle_percent = thr;
    t.roll_rate_dps = rr;
    t.pitch_rate_dps = pr;
    t.yaw_rate_dps = yr;
    t.roll_integral = ri;
    t.pitch_integral = pit;
    t.yaw_integral = yi;
    return t;
  endfunction

  // one integral whose magnitude is at least or below the per-axis minimum
  function automatic logic signed [INTEG_W-1:0] pick_integral(bit big);
    int unsigned m;
    logic signed [INTEG_W-1:0] v;
    if (big && $urandom_range(0, 15) == 0) return 16'sh8000;
    if (big) m = $urandom_range(32767, axis_min);
    else if (axis_min == 0) m = 0;
    else m = $urandom_range(axis_min - 1, 0);
    v = m[INTEG_W-1:0];
    if ($urandom_range(0, 1) == 1) v = -v;
    return v;
  endfunction

  function automatic tick_t random_tick(bit over);
    tick_t t;
    int unsigned r;
    int unsigned m;
    // time mostly runs forward, sometimes jumps or steps back
    r = $urandom_range(0, 99);
    if (r < 3) clock_us = $urandom();
    else if (r < 6) clock_us = clock_us - $urandom_range(1000, 1);
    else clock_us = clock_us + $urandom_range(step_max, 1);
    t.now_us = clock_us;
    t.active = ($urandom_range(0, 19) != 0);
    t.throttle_percent = $urandom_range(100, cur.throttle_min);
    t.roll_rate_dps = $urandom_range(cur.rate_limit, 0);
    t.pitch_rate_dps = $urandom_range(cur.rate_limit, 0);
    t.yaw_rate_dps = $urandom_range(cur.rate_limit, 0);
    // disqualifying ticks and raw noise
    r = $urandom_range(0, 99);
    if (r < 6 && cur.throttle_min > 0) begin
      t.throttle_percent = $urandom_range(cur.throttle_min - 1, 0);
    end else if (r < 12 && cur.rate_limit < 4095) begin
      case ($urandom_range(0, 2))
        0: t.roll_rate_dps = $urandom_range(4095, cur.rate_limit + 1);
        1: t.pitch_rate_dps = $urandom_range(4095, cur.rate_limit + 1);
        default: t.yaw_rate_dps = $urandom_range(4095, cur.rate_limit + 1);
      endcase
    end else if (r < 16) begin
      t.throttle_percent = $urandom();
      t.roll_rate_dps = $urandom();
      t.pitch_rate_dps = $urandom();
      t.yaw_rate_dps = $urandom();
    end
    // integrals: regime-driven, with some near the threshold and some noise
    r = $urandom_range(0, 99);
    if (r < 10) begin
      m = (axis_min > 32767) ? 32767 : axis_min;
      if (m > 0) m = m - $urandom_range(1, 0);
      t.roll_integral = m[INTEG_W-1:0];
      t.pitch_integral = $urandom_range(0, 1) ? -m[INTEG_W-1:0] : m[INTEG_W-1:0];
      t.yaw_integral = m[INTEG_W-1:0] + $urandom_range(1, 0);
    end else if (r < 20) begin
      t.roll_integral = $urandom();
      t.pitch_integral = $urandom();
      t.yaw_integral = $urandom();
    end else begin
      t.roll_integral = pick_integral(over);
      t.pitch_integral = pick_integral(over);
      t.yaw_integral = pick_integral(over);
    end
    return t;
  endfunction

  function automatic setting_t random_setting(int p);
    setting_t s;
    if (p == 0) begin
      s = '{8'd1, 8'd0, 8'd0, 12'd0, 7'd0, 24'd0};
    end else if (p == 1) begin
      s = '{8'd255, 8'd255, 8'd255, 12'd4095, 7'd100, 24'hFFFFFF};
    end else begin
      s.threshold = ($urandom_range(0, 2) == 0) ? $urandom_range(255, 1) : $urandom_range(8, 1);
      s.trig_tenths = ($urandom_range(0, 3) == 0) ? $urandom_range(255, 0) : $urandom_range(6, 0);
      s.untrig_tenths = ($urandom_range(0, 3) == 0) ? $urandom_range(255, 0) :
                        $urandom_range(6, 0);
      s.rate_limit = $urandom_range(4095, 50);
      s.throttle_min = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 0) :
                       $urandom_range(30, 0);
      s.inhibit_us = ($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(400000, 0);
    end
    return s;
  endfunction

  task automatic put_tick(tick_t t);
    int gap;
    // bursts of back-to-back ticks separated by idle gaps
    if (burst_left == 0) begin
      burst_left = $urandom_range(24, 1);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 1);
      if (gap > 0) begin
        tick.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    tick.valid <= 1'b1;
    tick.now_us <= t.now_us;
    tick.active <= t.active;
    tick.throttle_percent <= t.throttle_percent;
    tick.roll_rate_dps <= t.roll_rate_dps;
    tick.pitch_rate_dps <= t.pitch_rate_dps;
    tick.yaw_rate_dps <= t.yaw_rate_dps;
    tick.roll_integral <= t.roll_integral;
    tick.pitch_integral <= t.pitch_integral;
    tick.yaw_integral <= t.yaw_integral;
    do @(posedge clk); while (!tick.ready);
    sb.note_tick(t);
  endtask

  // stop sending and wait until every tick has its result
  task automatic end_phase();
    tick.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic apply_setting(setting_t s, bit poke_unmapped);
    logic [CFG_IDX_W-1:0]  idx [7];
    logic [CFG_DATA_W-1:0] val [7];
    logic [63:0] need;
    logic [63:0] m;
    int n;
    // unused upper data bits carry junk that must be masked off
    idx[0] = CFG_THRESHOLD;    val[0] = $urandom(); val[0][THR_W-1:0] = s.threshold;
    idx[1] = CFG_TRIG_DELAY;   val[1] = $urandom(); val[1][DELAY_W-1:0] = s.trig_tenths;
    idx[2] = CFG_UNTRIG_DELAY; val[2] = $urandom(); val[2][DELAY_W-1:0] = s.untrig_tenths;
    idx[3] = CFG_RATE_LIMIT;   val[3] = $urandom(); val[3][RATE_W-1:0] = s.rate_limit;
    idx[4] = CFG_THROTTLE_MIN; val[4] = $urandom(); val[4][THROTTLE_W-1:0] = s.throttle_min;
    idx[5] = CFG_INHIBIT_TIME; val[5] = s.inhibit_us;
    idx[6] = CFG_UNMAPPED;     val[6] = $urandom();
    n = poke_unmapped ? 7 : 6;
    for (int i = 0; i < n; i++) begin
      cfg.valid <= 1'b1;
      cfg.index <= idx[i];
      cfg.data <= val[i];
      do @(posedge clk); while (!cfg.ready);
      sb.write_reg(idx[i], val[i]);
    end
    cfg.valid <= 1'b0;
    // smallest per-axis magnitude whose cube reaches the threshold
    cur = s;
    need = s.threshold * PRODUCT_UNIT;
    m = 0;
    while (m < 32768 && m * m * m < need) m++;
    axis_min = m;
    step_max = (((s.trig_tenths > s.untrig_tenths) ? s.trig_tenths : s.untrig_tenths) *
                100000) / 8 + s.inhibit_us / 8 + 500;
  endtask

  initial begin
    setting_t s;
    tick_t t;
    bit over;
    int run_left;
    int unsigned r;
    sb = new();
    burst_left = 0;
    rst = 1'b1;
    tick.valid = 1'b0;
    tick.now_us = '0;
    tick.active = 1'b0;
    tick.throttle_percent = '0;
    tick.roll_rate_dps = '0;
    tick.pitch_rate_dps = '0;
    tick.yaw_rate_dps = '0;
    tick.roll_integral = '0;
    tick.pitch_integral = '0;
    tick.yaw_integral = '0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset registers: threshold zero keeps the detector idle
    put_tick(mk_tick(32'd0, 1'b1, 7'd0, 12'd0, 12'd0, 12'd0, 16'sd0, 16'sd0, 16'sd0));
    put_tick(mk_tick(32'hFFFF_FFFF, 1'b1, 7'd127, 12'd4095, 12'd4095, 12'd4095,
                     16'sd32767, -16'sd32768, -16'sd32768));
    put_tick(mk_tick(32'd1000, 1'b0, 7'd50, 12'd100, 12'd100, 12'd100,
                     -16'sd1, -16'sd1, -16'sd1));
    end_phase();

    // lowest threshold, short delays, no inhibit window
    s = '{8'd1, 8'd1, 8'd1, 12'd4095, 7'd10, 24'd0};
    apply_setting(s, 1'b1);
    // upper half of time after reset is still inhibited
    put_tick(mk_tick(32'h8000_0000, 1'b1, 7'd50, 12'd10, 12'd10, 12'd10,
                     16'sd800, 16'sd800, 16'sd640));
    // trigger deadline wraps to zero and is recomputed on the next tick
    put_tick(mk_tick(32'hFFFE_7960, 1'b1, 7'd0, 12'd10, 12'd10, 12'd10,
                     16'sd900, 16'sd900, 16'sd900));
    put_tick(mk_tick(32'd16, 1'b1, 7'd50, 12'd10, 12'd10, 12'd10,
                     16'sd900, 16'sd900, 16'sd900));
    put_tick(mk_tick(32'd100016, 1'b1, 7'd50, 12'd10, 12'd10, 12'd10,
                     16'sd900, -16'sd900, 16'sd900));
    // last integral one below, so the product is under the threshold
    put_tick(mk_tick(32'd150000, 1'b1, 7'd50, 12'd10, 12'd10, 12'd10,
                     16'sd800, 16'sd800, 16'sd639));
    put_tick(mk_tick(32'd200016, 1'b1, 7'd50, 12'd10, 12'd10, 12'd10,
                     16'sd800, 16'sd800, 16'sd639));
    // product exactly at the threshold, negative sign
    put_tick(mk_tick(32'd210000, 1'b1, 7'd50, 12'd10, 12'd10, 12'd10,
                     16'sd800, -16'sd800, 16'sd640));
    put_tick(mk_tick(32'd320000, 1'b1, 7'd9, 12'd4095, 12'd4095, 12'd4095,
                     16'sd800, -16'sd800, 16'sd640));
    put_tick(mk_tick(32'd330000, 1'b0, 7'd50, 12'd10, 12'd10, 12'd10,
                     16'sd800, -16'sd800, 16'sd640));
    end_phase();

    // highest threshold, zero delays, longest inhibit window
    s = '{8'd255, 8'd0, 8'd0, 12'd0, 7'd0, 24'hFFFFFF};
    apply_setting(s, 1'b0);
    put_tick(mk_tick(32'd1000, 1'b1, 7'd0, 12'd0, 12'd0, 12'd0,
                     -16'sd32768, -16'sd32768, -16'sd32768));
    put_tick(mk_tick(32'd2000, 1'b1, 7'd0, 12'd1, 12'd0, 12'd0,
                     -16'sd32768, -16'sd32768, -16'sd32768));
    put_tick(mk_tick(32'd16779214, 1'b1, 7'd0, 12'd0, 12'd0, 12'd0,
                     16'sd32767, 16'sd32767, 16'sd32767));
    put_tick(mk_tick(32'd16779215, 1'b1, 7'd0, 12'd0, 12'd0, 12'd0,
                     16'sd32767, 16'sd32767, 16'sd32767));
    put_tick(mk_tick(32'd16779216, 1'b1, 7'd0, 12'd0, 12'd0, 12'd0,
                     16'sd4705, 16'sd4705, 16'sd4705));
    end_phase();

    // random phases: runs above and below the threshold under varied settings
    for (int p = 0; p < PHASES; p++) begin
      s = random_setting(p);
      apply_setting(s, $urandom_range(0, 1));
      r = $urandom_range(0, 99);
      if (r < 70) clock_us = $urandom_range(32'h3000_0000, 0);
      else if (r < 85) clock_us = 32'h8000_0000 - $urandom_range(4 * step_max, 0);
      else clock_us = 32'hFFFF_FFFF - $urandom_range(4 * step_max, 0);
      over = 1'b0;
      run_left = 0;
      for (int i = 0; i < PHASE_TICKS; i++) begin
        if (run_left == 0) begin
          over = !over;
          run_left = $urandom_range(40, 1);
        end
        run_left--;
        t = random_tick(over);
        put_tick(t);
      end
      end_phase();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end
endmodule
